// ===== hdl/esc_pkg.sv =====
package esc_pkg;

    localparam int EPOCH_YEAR_DEF = 1970;

    localparam int SECS_W  = 32;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    localparam int DAYS_W  = 16;   // whole days fit 16 bits for any 32-bit input
    localparam int TOD_W   = 17;   // seconds of day < 86400
    localparam int PART_W  = 17;   // width of the largest divisor
    localparam int PC_W    = 4;

    // reciprocal multiplier operands
    localparam int MULA_W  = 25;
    localparam int MULB_W  = 26;

    localparam logic [PART_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [PART_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [PART_W-1:0] SECS_PER_MIN  = 17'd60;
    localparam logic [PART_W-1:0] DAYS_PER_WEEK = 17'd7;

    // Reciprocals, exact over each operand's range:
    //   (secs >> 7) / 675  : * RECIP_DAY  >> 35
    //   days / 7           : * RECIP_WEEK >> 19
    //   (tod >> 4) / 225   : * RECIP_HOUR >> 21
    //   (rest >> 2) / 15   : * RECIP_MIN  >> 14
    localparam logic [MULB_W-1:0] RECIP_DAY  = 26'd50903317;
    localparam logic [MULB_W-1:0] RECIP_WEEK = 26'd74899;
    localparam logic [MULB_W-1:0] RECIP_HOUR = 26'd9321;
    localparam logic [MULB_W-1:0] RECIP_MIN  = 26'd1093;

    localparam logic [8:0] DAYS_COMMON = 9'd365;
    localparam logic [8:0] DAYS_LEAP   = 9'd366;
    localparam logic [MONTH_W-1:0] LAST_MONTH_IDX = 4'd11;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_DIV,
        OP_SAVE_DAYS,
        OP_SAVE_WDAY,
        OP_SAVE_HOUR,
        OP_SAVE_MIN,
        OP_YEAR,
        OP_MONTH,
        OP_DONE,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        DSEL_DAY,
        DSEL_WEEK,
        DSEL_HOUR,
        DSEL_MIN
    } dsel_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_TAKEN,
        C_IN_NONE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        dsel_t           dsel;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic taken;
        logic in_none;
        logic out_busy;
    } dp_status_t;

    // Program addresses
    localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] PC_DIV_DAY   = 4'd1;
    localparam logic [PC_W-1:0] PC_SAVE_DAYS = 4'd2;
    localparam logic [PC_W-1:0] PC_DIV_WEEK  = 4'd3;
    localparam logic [PC_W-1:0] PC_SAVE_WDAY = 4'd4;
    localparam logic [PC_W-1:0] PC_DIV_HOUR  = 4'd5;
    localparam logic [PC_W-1:0] PC_SAVE_HOUR = 4'd6;
    localparam logic [PC_W-1:0] PC_DIV_MIN   = 4'd7;
    localparam logic [PC_W-1:0] PC_SAVE_MIN  = 4'd8;
    localparam logic [PC_W-1:0] PC_YEAR      = 4'd9;
    localparam logic [PC_W-1:0] PC_MONTH     = 4'd10;
    localparam logic [PC_W-1:0] PC_DONE      = 4'd11;
    localparam logic [PC_W-1:0] PC_WRAP      = 4'd12;

    function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
                                                   input logic leap);
        logic [DOM_W-1:0] len;
        case (mon)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/esc_ucode_rom.sv =====
module esc_ucode_rom (
    input  logic [esc_pkg::PC_W-1:0] pc,
    output esc_pkg::ctrl_word_t      ctrl
);

    always_comb begin
        case (pc)
            esc_pkg::PC_IDLE:      ctrl = '{esc_pkg::OP_IDLE, esc_pkg::DSEL_DAY,
                                            esc_pkg::C_IN_NONE, esc_pkg::PC_IDLE};
            esc_pkg::PC_DIV_DAY:   ctrl = '{esc_pkg::OP_DIV, esc_pkg::DSEL_DAY,
                                            esc_pkg::C_NEXT, esc_pkg::PC_IDLE};
            esc_pkg::PC_SAVE_DAYS: ctrl = '{esc_pkg::OP_SAVE_DAYS, esc_pkg::DSEL_DAY,
                                            esc_pkg::C_NEXT, esc_pkg::PC_IDLE};
            esc_pkg::PC_DIV_WEEK:  ctrl = '{esc_pkg::OP_DIV, esc_pkg::DSEL_WEEK,
                                            esc_pkg::C_NEXT, esc_pkg::PC_IDLE};
            esc_pkg::PC_SAVE_WDAY: ctrl = '{esc_pkg::OP_SAVE_WDAY, esc_pkg::DSEL_WEEK,
                                            esc_pkg::C_NEXT, esc_pkg::PC_IDLE};
            esc_pkg::PC_DIV_HOUR:  ctrl = '{esc_pkg::OP_DIV, esc_pkg::DSEL_HOUR,
                                            esc_pkg::C_NEXT, esc_pkg::PC_IDLE};
            esc_pkg::PC_SAVE_HOUR: ctrl = '{esc_pkg::OP_SAVE_HOUR, esc_pkg::DSEL_HOUR,
                                            esc_pkg::C_NEXT, esc_pkg::PC_IDLE};
            esc_pkg::PC_DIV_MIN:   ctrl = '{esc_pkg::OP_DIV, esc_pkg::DSEL_MIN,
                                            esc_pkg::C_NEXT, esc_pkg::PC_IDLE};
            esc_pkg::PC_SAVE_MIN:  ctrl = '{esc_pkg::OP_SAVE_MIN, esc_pkg::DSEL_MIN,
                                            esc_pkg::C_NEXT, esc_pkg::PC_IDLE};
            esc_pkg::PC_YEAR:      ctrl = '{esc_pkg::OP_YEAR, esc_pkg::DSEL_DAY,
                                            esc_pkg::C_TAKEN, esc_pkg::PC_YEAR};
            esc_pkg::PC_MONTH:     ctrl = '{esc_pkg::OP_MONTH, esc_pkg::DSEL_DAY,
                                            esc_pkg::C_TAKEN, esc_pkg::PC_MONTH};
            esc_pkg::PC_DONE:      ctrl = '{esc_pkg::OP_DONE, esc_pkg::DSEL_DAY,
                                            esc_pkg::C_OUT_BUSY, esc_pkg::PC_DONE};
            esc_pkg::PC_WRAP:      ctrl = '{esc_pkg::OP_NOP, esc_pkg::DSEL_DAY,
                                            esc_pkg::C_ALWAYS, esc_pkg::PC_IDLE};
            default:               ctrl = '{esc_pkg::OP_NOP, esc_pkg::DSEL_DAY,
                                            esc_pkg::C_ALWAYS, esc_pkg::PC_IDLE};
        endcase
    end

endmodule

// ===== hdl/esc_sequencer.sv =====
module esc_sequencer (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  esc_pkg::ctrl_word_t      ctrl,
    input  esc_pkg::dp_status_t      status,
    output logic [esc_pkg::PC_W-1:0] pc
);

    logic [esc_pkg::PC_W-1:0] pc_reg;
    logic [esc_pkg::PC_W-1:0] pc_next;
    logic                     jump;

    always_comb begin
        case (ctrl.cond)
            esc_pkg::C_NEXT:     jump = 1'b0;
            esc_pkg::C_ALWAYS:   jump = 1'b1;
            esc_pkg::C_TAKEN:    jump = status.taken;
            esc_pkg::C_IN_NONE:  jump = status.in_none;
            esc_pkg::C_OUT_BUSY: jump = status.out_busy;
            default:             jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= esc_pkg::PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign pc = pc_reg;

endmodule

// ===== hdl/esc_datapath.sv =====
module esc_datapath #(
    parameter int EPOCH_YEAR = esc_pkg::EPOCH_YEAR_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  esc_pkg::ctrl_word_t          ctrl,
    output esc_pkg::dp_status_t          status,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [esc_pkg::SECS_W-1:0]   s_epoch_seconds,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [esc_pkg::YEAR_W-1:0]   m_year,
    output logic [esc_pkg::MONTH_W-1:0]  m_month,
    output logic [esc_pkg::DOM_W-1:0]    m_day_of_month,
    output logic [esc_pkg::WDAY_W-1:0]   m_weekday,
    output logic [esc_pkg::HOUR_W-1:0]   m_hour,
    output logic [esc_pkg::MIN_W-1:0]    m_minute,
    output logic [esc_pkg::SEC_W-1:0]    m_second
);

    localparam logic [1:0] M4_INIT   = 2'(EPOCH_YEAR % 4);
    localparam logic [6:0] M100_INIT = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0] M400_INIT = 9'(EPOCH_YEAR % 400);

    // quotient by reciprocal, remainder by multiply and subtract
    logic [esc_pkg::SECS_W-1:0]  dvd_reg, dvd_next;
    logic [esc_pkg::DAYS_W-1:0]  quot_reg, quot_next;
    logic [esc_pkg::MULA_W-1:0]  mul_a;
    logic [esc_pkg::MULB_W-1:0]  mul_b;
    logic [esc_pkg::MULA_W+esc_pkg::MULB_W-1:0] prod;
    logic [esc_pkg::DAYS_W-1:0]  quot;
    logic [esc_pkg::PART_W-1:0]  divisor;
    logic [esc_pkg::SECS_W-1:0]  quot_x_div;
    logic [esc_pkg::SECS_W-1:0]  rem_full;

    // calendar work registers
    logic [esc_pkg::DAYS_W-1:0]  days_reg, days_next;
    logic [esc_pkg::TOD_W-1:0]   tod_reg, tod_next;
    logic [esc_pkg::YEAR_W-1:0]  year_reg, year_next;
    logic [esc_pkg::MONTH_W-1:0] mon_reg, mon_next;
    logic [1:0]                  m4_reg, m4_next;
    logic [6:0]                  m100_reg, m100_next;
    logic [8:0]                  m400_reg, m400_next;
    logic [esc_pkg::WDAY_W-1:0]  wday_reg, wday_next;
    logic [esc_pkg::HOUR_W-1:0]  hour_reg, hour_next;
    logic [esc_pkg::MIN_W-1:0]   min_reg, min_next;
    logic [esc_pkg::SEC_W-1:0]   sec_reg, sec_next;

    logic                        leap;
    logic [8:0]                  ylen;
    logic [esc_pkg::DOM_W-1:0]   mlen;
    logic                        year_ge, month_ge;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic                         out_busy;
    logic [esc_pkg::YEAR_W-1:0]   o_year_reg, o_year_next;
    logic [esc_pkg::MONTH_W-1:0]  o_month_reg, o_month_next;
    logic [esc_pkg::DOM_W-1:0]    o_dom_reg, o_dom_next;
    logic [esc_pkg::WDAY_W-1:0]   o_wday_reg, o_wday_next;
    logic [esc_pkg::HOUR_W-1:0]   o_hour_reg, o_hour_next;
    logic [esc_pkg::MIN_W-1:0]    o_min_reg, o_min_next;
    logic [esc_pkg::SEC_W-1:0]    o_sec_reg, o_sec_next;

    // low divisor factors of two are dropped before the multiply
    always_comb begin
        case (ctrl.dsel)
            esc_pkg::DSEL_DAY: begin
                divisor = esc_pkg::SECS_PER_DAY;
                mul_a   = dvd_reg[31:7];
                mul_b   = esc_pkg::RECIP_DAY;
            end
            esc_pkg::DSEL_WEEK: begin
                divisor = esc_pkg::DAYS_PER_WEEK;
                mul_a   = {9'd0, dvd_reg[15:0]};
                mul_b   = esc_pkg::RECIP_WEEK;
            end
            esc_pkg::DSEL_HOUR: begin
                divisor = esc_pkg::SECS_PER_HOUR;
                mul_a   = {12'd0, dvd_reg[16:4]};
                mul_b   = esc_pkg::RECIP_HOUR;
            end
            esc_pkg::DSEL_MIN: begin
                divisor = esc_pkg::SECS_PER_MIN;
                mul_a   = {15'd0, dvd_reg[11:2]};
                mul_b   = esc_pkg::RECIP_MIN;
            end
            default: begin
                divisor = esc_pkg::SECS_PER_DAY;
                mul_a   = dvd_reg[31:7];
                mul_b   = esc_pkg::RECIP_DAY;
            end
        endcase
    end

    assign prod = {{esc_pkg::MULB_W{1'b0}}, mul_a} * {{esc_pkg::MULA_W{1'b0}}, mul_b};

    always_comb begin
        case (ctrl.dsel)
            esc_pkg::DSEL_DAY:  quot = prod[50:35];
            esc_pkg::DSEL_WEEK: quot = prod[34:19];
            esc_pkg::DSEL_HOUR: quot = prod[36:21];
            esc_pkg::DSEL_MIN:  quot = prod[29:14];
            default:            quot = prod[50:35];
        endcase
    end

    assign quot_x_div = esc_pkg::SECS_W'(quot_reg) * esc_pkg::SECS_W'(divisor);
    assign rem_full   = dvd_reg - quot_x_div;

    assign leap     = (m400_reg == 9'd0) || ((m100_reg != 7'd0) && (m4_reg == 2'd0));
    assign ylen     = leap ? esc_pkg::DAYS_LEAP : esc_pkg::DAYS_COMMON;
    assign mlen     = esc_pkg::month_len(mon_reg, leap);
    assign year_ge  = days_reg >= esc_pkg::DAYS_W'(ylen);
    assign month_ge = (mon_reg < esc_pkg::LAST_MONTH_IDX) &&
                      (days_reg >= esc_pkg::DAYS_W'(mlen));

    assign out_busy = out_valid_reg && !m_ready;

    always_comb begin
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        days_next = days_reg;
        tod_next  = tod_reg;
        year_next = year_reg;
        mon_next  = mon_reg;
        m4_next   = m4_reg;
        m100_next = m100_reg;
        m400_next = m400_reg;
        wday_next = wday_reg;
        hour_next = hour_reg;
        min_next  = min_reg;
        sec_next  = sec_reg;

        out_valid_next = out_valid_reg && !m_ready;
        o_year_next    = o_year_reg;
        o_month_next   = o_month_reg;
        o_dom_next     = o_dom_reg;
        o_wday_next    = o_wday_reg;
        o_hour_next    = o_hour_reg;
        o_min_next     = o_min_reg;
        o_sec_next     = o_sec_reg;

        case (ctrl.op)
            esc_pkg::OP_IDLE: begin
                if (s_valid) begin
                    dvd_next = s_epoch_seconds;
                end
            end
            esc_pkg::OP_DIV: begin
                quot_next = quot;
            end
            esc_pkg::OP_SAVE_DAYS: begin
                days_next = quot_reg;
                tod_next  = rem_full[esc_pkg::TOD_W-1:0];
                dvd_next  = esc_pkg::SECS_W'(quot_reg);
            end
            esc_pkg::OP_SAVE_WDAY: begin
                wday_next = rem_full[esc_pkg::WDAY_W-1:0] + 1'b1;
                dvd_next  = esc_pkg::SECS_W'(tod_reg);
            end
            esc_pkg::OP_SAVE_HOUR: begin
                hour_next = quot_reg[esc_pkg::HOUR_W-1:0];
                dvd_next  = rem_full;
            end
            esc_pkg::OP_SAVE_MIN: begin
                min_next  = quot_reg[esc_pkg::MIN_W-1:0];
                sec_next  = rem_full[esc_pkg::SEC_W-1:0];
                year_next = esc_pkg::YEAR_W'(EPOCH_YEAR);
                m4_next   = M4_INIT;
                m100_next = M100_INIT;
                m400_next = M400_INIT;
                mon_next  = '0;
            end
            esc_pkg::OP_YEAR: begin
                if (year_ge) begin
                    days_next = days_reg - esc_pkg::DAYS_W'(ylen);
                    year_next = year_reg + 1'b1;
                    m4_next   = m4_reg + 1'b1;
                    m100_next = (m100_reg == 7'd99)  ? 7'd0 : m100_reg + 1'b1;
                    m400_next = (m400_reg == 9'd399) ? 9'd0 : m400_reg + 1'b1;
                end
            end
            esc_pkg::OP_MONTH: begin
                if (month_ge) begin
                    days_next = days_reg - esc_pkg::DAYS_W'(mlen);
                    mon_next  = mon_reg + 1'b1;
                end
            end
            esc_pkg::OP_DONE: begin
                if (!out_busy) begin
                    out_valid_next = 1'b1;
                    o_year_next    = year_reg;
                    o_month_next   = mon_reg + 1'b1;
                    o_dom_next     = days_reg[esc_pkg::DOM_W-1:0] + 1'b1;
                    o_wday_next    = wday_reg;
                    o_hour_next    = hour_reg;
                    o_min_next     = min_reg;
                    o_sec_next     = sec_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg     <= dvd_next;
        quot_reg    <= quot_next;
        days_reg    <= days_next;
        tod_reg     <= tod_next;
        year_reg    <= year_next;
        mon_reg     <= mon_next;
        m4_reg      <= m4_next;
        m100_reg    <= m100_next;
        m400_reg    <= m400_next;
        wday_reg    <= wday_next;
        hour_reg    <= hour_next;
        min_reg     <= min_next;
        sec_reg     <= sec_next;
        o_year_reg  <= o_year_next;
        o_month_reg <= o_month_next;
        o_dom_reg   <= o_dom_next;
        o_wday_reg  <= o_wday_next;
        o_hour_reg  <= o_hour_next;
        o_min_reg   <= o_min_next;
        o_sec_reg   <= o_sec_next;
    end

    always_comb begin
        status.taken    = (ctrl.op == esc_pkg::OP_YEAR)  ? year_ge  :
                          (ctrl.op == esc_pkg::OP_MONTH) ? month_ge : 1'b0;
        status.in_none  = !s_valid;
        status.out_busy = out_busy;
    end

    assign s_ready        = ctrl.op == esc_pkg::OP_IDLE;
    assign m_valid        = out_valid_reg;
    assign m_year         = o_year_reg;
    assign m_month        = o_month_reg;
    assign m_day_of_month = o_dom_reg;
    assign m_weekday      = o_wday_reg;
    assign m_hour         = o_hour_reg;
    assign m_minute       = o_min_reg;
    assign m_second       = o_sec_reg;

    // reciprocal quotient is exact: remainder lands below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == esc_pkg::OP_SAVE_DAYS || ctrl.op == esc_pkg::OP_SAVE_WDAY ||
         ctrl.op == esc_pkg::OP_SAVE_HOUR || ctrl.op == esc_pkg::OP_SAVE_MIN)
        |-> (rem_full < esc_pkg::SECS_W'(divisor)))
        else $error("remainder out of range");

    // year stepping leaves less than one year of days
    a_days_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == esc_pkg::OP_MONTH) |-> (days_reg < esc_pkg::DAYS_W'(ylen)))
        else $error("day remainder exceeds year length");

    // month index never walks past December and the day stays below 31
    a_month_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == esc_pkg::OP_DONE) |-> (mon_reg <= esc_pkg::LAST_MONTH_IDX &&
                                           days_reg < 16'd31))
        else $error("month or day out of range at completion");

    // a finished result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == esc_pkg::OP_DONE && out_busy) |=> out_valid_reg)
        else $error("pending result lost");

endmodule

// ===== hdl/epoch_seconds_to_calendar_top.sv =====
// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+------------------------------------------------
// s_       | in        | s_valid / s_ready | s_epoch_seconds[31:0]
// m_       | out       | m_valid / m_ready | m_year, m_month, m_day_of_month, m_weekday,
//          |           |                   | m_hour, m_minute, m_second
//
// One item at a time. From its transfer until s_ready is high again, an item
// passes the division steps, the year loop over Y whole years, the month loop
// over M (0..11) months, Y + M being at most 146, and the final load step,
// which waits while the output register is full. The year loop dominates.
// Reset (aresetn low, synchronous) returns the sequencer to its idle step and
// empties the output register. A result waits in the output register while the
// next item is already being converted; only the final load step stalls on m_ready.
module epoch_seconds_to_calendar_top #(
    parameter int EPOCH_YEAR = esc_pkg::EPOCH_YEAR_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [esc_pkg::SECS_W-1:0]   s_epoch_seconds,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [esc_pkg::YEAR_W-1:0]   m_year,
    output logic [esc_pkg::MONTH_W-1:0]  m_month,
    output logic [esc_pkg::DOM_W-1:0]    m_day_of_month,
    output logic [esc_pkg::WDAY_W-1:0]   m_weekday,
    output logic [esc_pkg::HOUR_W-1:0]   m_hour,
    output logic [esc_pkg::MIN_W-1:0]    m_minute,
    output logic [esc_pkg::SEC_W-1:0]    m_second
);

    // Program, one control word per step:
    //   idle/transfer -> secs/86400 -> days/7 -> tod/3600 -> rest/60
    //   -> year stepping -> month stepping -> result load -> return to idle.
    // Each division is two steps: a quotient from one shared 25x26 reciprocal
    // multiply, then the remainder by a small multiply and subtract.
    logic [esc_pkg::PC_W-1:0] pc;
    esc_pkg::ctrl_word_t      ctrl;
    esc_pkg::dp_status_t      status;

    esc_ucode_rom u_rom (
        .pc   (pc),
        .ctrl (ctrl)
    );

    // step counter; conditional jumps on step taken,
    // input absent and output busy
    esc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .status  (status),
        .pc      (pc)
    );

    // shared divider, year/month stepping and the output register
    esc_datapath #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .status          (status),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_epoch_seconds (s_epoch_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_year          (m_year),
        .m_month         (m_month),
        .m_day_of_month  (m_day_of_month),
        .m_weekday       (m_weekday),
        .m_hour          (m_hour),
        .m_minute        (m_minute),
        .m_second        (m_second)
    );

endmodule

// ===== test/calendar_checker.sv =====
`timescale 1ns / 100ps

module calendar_checker #(
    parameter int EPOCH_YEAR = esc_pkg::EPOCH_YEAR_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [esc_pkg::SECS_W-1:0]   s_epoch_seconds,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [esc_pkg::YEAR_W-1:0]   m_year,
    input  logic [esc_pkg::MONTH_W-1:0]  m_month,
    input  logic [esc_pkg::DOM_W-1:0]    m_day_of_month,
    input  logic [esc_pkg::WDAY_W-1:0]   m_weekday,
    input  logic [esc_pkg::HOUR_W-1:0]   m_hour,
    input  logic [esc_pkg::MIN_W-1:0]    m_minute,
    input  logic [esc_pkg::SEC_W-1:0]    m_second,
    output int                           mismatches,
    output int                           outstanding,
    output int                           results_checked
);

    typedef struct packed {
        logic [esc_pkg::YEAR_W-1:0]  year;
        logic [esc_pkg::MONTH_W-1:0] month;
        logic [esc_pkg::DOM_W-1:0]   day_of_month;
        logic [esc_pkg::WDAY_W-1:0]  weekday;
        logic [esc_pkg::HOUR_W-1:0]  hour;
        logic [esc_pkg::MIN_W-1:0]   minute;
        logic [esc_pkg::SEC_W-1:0]   second;
    } calendar_t;

    // Non-leap month lengths, January in the low five bits.
    localparam logic [12*5-1:0] MONTH_LENGTHS = {
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
        5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31
    };

    calendar_t calendar_q [$];
    calendar_t want_cal;
    int        errs    = 0;
    int        checked = 0;

    function automatic bit gregorian_leap(input int unsigned yr);
        return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    endfunction

    function automatic calendar_t calendar_of(input logic [esc_pkg::SECS_W-1:0] secs);
        calendar_t   cal;
        int unsigned days;
        int unsigned tod;
        int unsigned left;
        int unsigned yr;
        int unsigned mon;
        int unsigned span;
        days = secs / 86400;
        tod  = secs % 86400;
        left = days;
        yr   = EPOCH_YEAR;
        // skip whole years, each tested against its own length
        forever begin
            span = gregorian_leap(yr) ? 366 : 365;
            if (left < span) break;
            left -= span;
            yr++;
        end
        mon = 0;
        while (mon < 11) begin
            span = 32'(MONTH_LENGTHS[mon*5 +: 5]);
            if (mon == 1 && gregorian_leap(yr)) span = 29;
            if (left < span) break;
            left -= span;
            mon++;
        end
        cal.year         = esc_pkg::YEAR_W'(yr);
        cal.month        = esc_pkg::MONTH_W'(mon + 1);
        cal.day_of_month = esc_pkg::DOM_W'(left + 1);
        cal.weekday      = esc_pkg::WDAY_W'((days % 7) + 1);
        cal.hour         = esc_pkg::HOUR_W'(tod / 3600);
        cal.minute       = esc_pkg::MIN_W'((tod % 3600) / 60);
        cal.second       = esc_pkg::SEC_W'(tod % 60);
        return cal;
    endfunction

    function automatic int field_bad(input string name, input int unsigned want,
                                     input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            calendar_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                calendar_q.push_back(calendar_of(s_epoch_seconds));
            end
            if (m_valid && m_ready) begin
                if (calendar_q.size() == 0) begin
                    $error("result transfer with no conversion pending: %0d-%0d-%0d",
                           m_year, m_month, m_day_of_month);
                    errs++;
                end else begin
                    want_cal = calendar_q.pop_front();
                    errs += field_bad("year", want_cal.year, m_year);
                    errs += field_bad("month", want_cal.month, m_month);
                    errs += field_bad("day_of_month", want_cal.day_of_month, m_day_of_month);
                    errs += field_bad("weekday", want_cal.weekday, m_weekday);
                    errs += field_bad("hour", want_cal.hour, m_hour);
                    errs += field_bad("minute", want_cal.minute, m_minute);
                    errs += field_bad("second", want_cal.second, m_second);
                    checked++;
                end
            end
        end
        mismatches      <= errs;
        outstanding     <= calendar_q.size();
        results_checked <= checked;
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the epoch-seconds to calendar converter.
// All prediction and comparison lives in calendar_checker; this module only
// drives the input channel, throttles the result channel and decides the end.
module tb;

    localparam int          EPOCH_YEAR    = esc_pkg::EPOCH_YEAR_DEF;
    localparam int          RANDOM_ITEMS  = 1150;
    localparam int          STEADY_FIRST  = 500;   // no idling on either side
    localparam int          STEADY_LAST   = 699;   // for this stretch of items
    localparam int          MID_PAUSE_AT  = 900;
    localparam int          TAIL_CYCLES   = 250;   // longer than a worst-case conversion
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned LAST_FULL_DAY = 49709; // last day whose 86399th second fits

    logic                         aclk            = 1'b0;
    logic                         aresetn         = 1'b0;
    logic                         s_valid         = 1'b0;
    logic                         s_ready;
    logic [esc_pkg::SECS_W-1:0]   s_epoch_seconds = '0;
    logic                         m_valid;
    logic                         m_ready         = 1'b0;
    logic [esc_pkg::YEAR_W-1:0]   m_year;
    logic [esc_pkg::MONTH_W-1:0]  m_month;
    logic [esc_pkg::DOM_W-1:0]    m_day_of_month;
    logic [esc_pkg::WDAY_W-1:0]   m_weekday;
    logic [esc_pkg::HOUR_W-1:0]   m_hour;
    logic [esc_pkg::MIN_W-1:0]    m_minute;
    logic [esc_pkg::SEC_W-1:0]    m_second;

    logic steady = 1'b0;   // suppresses idling on both sides while high
    int   mismatches;
    int   outstanding;
    int   results_checked;
    int   directed_sent = 0;
    int   random_sent   = 0;

    // Corner timestamps. The epoch day is weekday 1.
    logic [31:0] corner_secs [$] = '{
        32'd0,                          // epoch start
        32'd59, 32'd60,                 // minute rollover
        32'd3599, 32'd3600,             // hour rollover
        32'd86399, 32'd86400,           // day rollover
        32'd604799, 32'd604800,         // weekday 7, then back to 1
        32'd2678399, 32'd2678400,       // end of January, first of February
        32'd31535999, 32'd31536000,     // last second of 1970, first of 1971
        32'd36633600,                   // 1971-03-01, day after a common February
        32'd62985600,                   // 1971-12-31, last day of a common year
        32'd63072000,                   // 1972-01-01
        32'd951782400,                  // 2000-02-29, century divisible by 400
        32'd978220800,                  // 2000-12-31
        32'd4107456000,                 // 2100-02-28, century that is not leap
        32'd4107542400,                 // 2100-03-01
        32'd2147483647, 32'd2147483648, // signed-overflow boundary
        32'hFFFF_FFFF,                  // largest input, early 2106
        32'hAAAA_AAAA, 32'h5555_5555    // alternating bit patterns
    };

    epoch_seconds_to_calendar_top #(
        .EPOCH_YEAR(EPOCH_YEAR)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_epoch_seconds(s_epoch_seconds),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_year         (m_year),
        .m_month        (m_month),
        .m_day_of_month (m_day_of_month),
        .m_weekday      (m_weekday),
        .m_hour         (m_hour),
        .m_minute       (m_minute),
        .m_second       (m_second)
    );

    calendar_checker #(
        .EPOCH_YEAR(EPOCH_YEAR)
    ) calendar_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_epoch_seconds(s_epoch_seconds),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_year         (m_year),
        .m_month        (m_month),
        .m_day_of_month (m_day_of_month),
        .m_weekday      (m_weekday),
        .m_hour         (m_hour),
        .m_minute       (m_minute),
        .m_second       (m_second),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_checked(results_checked)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver: m_ready drops at random with a chance of 15 percent, never during the steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 15);
    end

    // One input transfer. Idle cycles before it drop valid and scramble the
    // payload, so a converter that samples without valid gets caught.
    // Called and returning on a rising edge; valid is left high.
    task automatic send_seconds(input logic [31:0] secs);
        while (!steady && $urandom_range(0, 99) < 15) begin
            s_valid         <= 1'b0;
            s_epoch_seconds <= $urandom;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_epoch_seconds <= secs;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Sender holds off until every predicted result has been transferred.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    initial begin
        logic [31:0] secs;
        int unsigned pick;
        int unsigned day;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (corner_secs[i]) begin
            send_seconds(corner_secs[i]);
            directed_sent++;
        end
        hold_until_drained();

        // Random part: full-range words, day boundaries (month, year and
        // weekday edges come with them), random times of day, and the two
        // ends of the input range.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == STEADY_FIRST) steady <= 1'b1;
            if (n == STEADY_LAST + 1) steady <= 1'b0;
            if (n == MID_PAUSE_AT) hold_until_drained();
            pick = $urandom_range(0, 9);
            day  = $urandom_range(0, LAST_FULL_DAY);
            if (pick < 4) begin
                secs = $urandom;
            end else if (pick < 8) begin
                secs = day * SECS_PER_DAY + ($urandom_range(0, 1) ? SECS_PER_DAY - 1 : 0);
            end else if (pick == 8) begin
                secs = day * SECS_PER_DAY + $urandom_range(0, SECS_PER_DAY - 1);
            end else if ($urandom_range(0, 1)) begin
                secs = $urandom_range(0, 4000);
            end else begin
                secs = 32'hFFFF_FFFF - $urandom_range(0, 4000);
            end
            send_seconds(secs);
            random_sent++;
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d timestamps sent (%0d corner cases, %0d random), %0d dates checked",
                 directed_sent + random_sent, directed_sent, random_sent, results_checked);
        $display("span: epoch start to 2106, leap days, both century rules, all weekdays");
        if (mismatches == 0 && outstanding == 0) begin
            $display("epoch_seconds_to_calendar_top regression: pass");
        end else begin
            $display("epoch_seconds_to_calendar_top regression: fail");
        end
        $finish;
    end

    // Watchdog: fails the run if it has not finished by this time limit.
    initial begin
        #20_000_000;
        $display("epoch_seconds_to_calendar_top regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/esc_pkg.sv
hdl/esc_ucode_rom.sv
hdl/esc_sequencer.sv
hdl/esc_datapath.sv
hdl/epoch_seconds_to_calendar_top.sv
test/calendar_checker.sv
test/tb.sv
